@@ rtl/gpio_irq_pkg.sv @@
// shared types and constants for the gpio port with interrupt detect
package gpio_irq_pkg;

    // pin group size and word widths
    localparam int PIN_COUNT = 8;
    localparam int DATA_W    = 8;
    localparam int CFG_IDX_W = 3;

    // bits that take part in every register and value
    localparam logic [DATA_W-1:0] PIN_MASK =
        DATA_W'(((64'd1 << PIN_COUNT) - 64'd1) & ((64'd1 << DATA_W) - 64'd1));

    // word kinds
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    // register selects for bus accesses
    typedef enum logic [1:0] {
        SEL_DATA   = 2'd0,
        SEL_RAW    = 2'd1,
        SEL_MASKED = 2'd2,
        SEL_CLEAR  = 2'd3
    } t_sel;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION = 3'd0,
        CFG_LEVEL     = 3'd1,
        CFG_BOTH      = 3'd2,
        CFG_POLARITY  = 3'd3,
        CFG_IRQ_EN    = 3'd4
    } t_cfg_idx;

    // configuration set seen by the core
    typedef struct packed {
        logic [DATA_W-1:0] direction;
        logic [DATA_W-1:0] level_sense;
        logic [DATA_W-1:0] both_edges;
        logic [DATA_W-1:0] polarity;
        logic [DATA_W-1:0] irq_en;
    } t_cfg;

    // one input word
    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        reg_sel;
        logic [DATA_W-1:0] bit_mask;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] pins_in;
    } t_item;

    // one result word
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] pins_out;
        logic [DATA_W-1:0] pins_drive;
        logic              irq;
    } t_result;

endpackage

@@ rtl/gpio_irq_cfg.sv @@
// configuration register file of the gpio port
module gpio_irq_cfg import gpio_irq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg              r_cfg;
    t_cfg              n_cfg;
    logic [DATA_W-1:0] s_val;

    // unused pins always read as zero
    assign s_val = i_cfg_wdata & PIN_MASK;

    // write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIRECTION: n_cfg.direction   = s_val;
                CFG_LEVEL:     n_cfg.level_sense = s_val;
                CFG_BOTH:      n_cfg.both_edges  = s_val;
                CFG_POLARITY:  n_cfg.polarity    = s_val;
                CFG_IRQ_EN:    n_cfg.irq_en      = s_val;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/gpio_irq_core.sv @@
// port state, event detection and register access for one word
module gpio_irq_core import gpio_irq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [DATA_W-1:0] r_out_data;
    logic [DATA_W-1:0] r_last_sample;
    logic [DATA_W-1:0] r_raw_status;
    logic [DATA_W-1:0] r_pin_levels;
    logic [DATA_W-1:0] n_out_data;
    logic [DATA_W-1:0] n_last_sample;
    logic [DATA_W-1:0] n_raw_status;
    logic [DATA_W-1:0] n_pin_levels;

    logic [DATA_W-1:0] s_mask;
    logic [DATA_W-1:0] s_wdata;
    logic [DATA_W-1:0] s_pins;
    logic [DATA_W-1:0] s_rise;
    logic [DATA_W-1:0] s_fall;
    logic [DATA_W-1:0] s_one_edge;
    logic [DATA_W-1:0] s_edge_ev;
    logic [DATA_W-1:0] s_level_match;
    logic [DATA_W-1:0] s_tick_status;
    logic [DATA_W-1:0] s_rdata;

    assign s_mask  = i_item.bit_mask & PIN_MASK;
    assign s_wdata = i_item.write_data & PIN_MASK;
    assign s_pins  = i_item.pins_in & PIN_MASK;

    // per pin event detection on a sample tick
    assign s_rise        = s_pins & ~r_last_sample;
    assign s_fall        = r_last_sample & ~s_pins;
    assign s_one_edge    = (s_rise & i_cfg.polarity) | (s_fall & ~i_cfg.polarity);
    assign s_edge_ev     = (i_cfg.both_edges & (s_rise | s_fall))
                         | (~i_cfg.both_edges & s_one_edge);
    assign s_level_match = ~(s_pins ^ i_cfg.polarity);
    assign s_tick_status = (((r_raw_status | s_edge_ev) & ~i_cfg.level_sense)
                         | (s_level_match & i_cfg.level_sense)) & PIN_MASK;

    // next state
    always_comb begin
        n_out_data    = r_out_data;
        n_last_sample = r_last_sample;
        n_raw_status  = r_raw_status;
        n_pin_levels  = r_pin_levels;
        case (i_item.kind)
            KIND_TICK: begin
                n_raw_status  = s_tick_status;
                n_last_sample = s_pins;
                n_pin_levels  = s_pins;
            end
            KIND_WRITE: begin
                case (i_item.reg_sel)
                    SEL_DATA:  n_out_data   = ((r_out_data & ~s_mask) | (s_wdata & s_mask))
                                            & PIN_MASK;
                    SEL_CLEAR: n_raw_status = r_raw_status & ~s_wdata;
                    default:   n_out_data   = r_out_data;
                endcase
            end
            default: n_out_data = r_out_data;
        endcase
    end

    // read mux
    always_comb begin
        s_rdata = '0;
        if (i_item.kind == KIND_READ) begin
            case (i_item.reg_sel)
                SEL_DATA:   s_rdata = ((r_out_data & i_cfg.direction)
                                    | (r_pin_levels & ~i_cfg.direction)) & s_mask;
                SEL_RAW:    s_rdata = r_raw_status;
                SEL_MASKED: s_rdata = r_raw_status & i_cfg.irq_en;
                default:    s_rdata = '0;
            endcase
        end
    end

    // result after this word's update
    assign o_result.read_data  = s_rdata;
    assign o_result.pins_out   = n_out_data & i_cfg.direction;
    assign o_result.pins_drive = i_cfg.direction;
    assign o_result.irq        = |(n_raw_status & i_cfg.irq_en);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_data    <= '0;
            r_last_sample <= '0;
            r_raw_status  <= '0;
            r_pin_levels  <= '0;
        end else if (i_step) begin
            r_out_data    <= n_out_data;
            r_last_sample <= n_last_sample;
            r_raw_status  <= n_raw_status;
            r_pin_levels  <= n_pin_levels;
        end
    end

endmodule

@@ rtl/gpio_port_with_interrupt_detect.sv @@
// top level: input register, gpio core and result register
// an accepted word waits in the input register, then goes through the core into the
// result register, from which the receiver takes it
// throughput: one word per cycle; a stalled result word holds the word in the input register
// the slow path is the core's per-bit gate logic between the two registers
// reset: synchronous, active low; clears config, pin state, status and valid flags
module gpio_port_with_interrupt_detect import gpio_irq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_kind,
    input  logic [1:0]           i_reg_sel,
    input  logic [DATA_W-1:0]    i_bit_mask,
    input  logic [DATA_W-1:0]    i_write_data,
    input  logic [DATA_W-1:0]    i_pins_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DATA_W-1:0]    o_read_data,
    output logic [DATA_W-1:0]    o_pins_out,
    output logic [DATA_W-1:0]    o_pins_drive,
    output logic                 o_irq
);

    t_cfg    s_cfg;
    t_result s_core_result;
    t_item   r_item;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    s_out_free;
    logic    s_adv;
    logic    s_in_take;

    // handshake control
    assign s_out_free = !r_out_valid || i_out_ready;
    assign s_adv      = r_in_valid && s_out_free;
    assign o_in_ready = !r_in_valid || s_out_free;
    assign s_in_take  = i_in_valid && o_in_ready;

    gpio_irq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (s_cfg)
    );

    gpio_irq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s_adv),
        .i_item   (r_item),
        .i_cfg    (s_cfg),
        .o_result (s_core_result)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_item.kind       <= i_kind;
            r_item.reg_sel    <= i_reg_sel;
            r_item.bit_mask   <= i_bit_mask;
            r_item.write_data <= i_write_data;
            r_item.pins_in    <= i_pins_in;
        end
        if (s_adv) begin
            r_result <= s_core_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_result.read_data;
    assign o_pins_out   = r_result.pins_out;
    assign o_pins_drive = r_result.pins_drive;
    assign o_irq        = r_result.irq;

    // input register never drops a waiting word
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !s_adv |=> r_in_valid)
        else $error("waiting input word lost");

    // an empty input register always takes a word
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("empty input register not ready");

    // only reads give nonzero read data
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && (r_item.kind != KIND_READ) |=> o_read_data == '0)
        else $error("read data nonzero for a non-read word");

    // input pins never show output data
    a_pins_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pins_out & ~o_pins_drive) == '0)
        else $error("output data on an input pin");

    // an advancing word always lands in the result register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv |=> o_out_valid)
        else $error("result word not loaded");

endmodule
